/* hdl/pat_pkg.sv */
// Shared types and constants for the packet acknowledgement tracker.
`timescale 1ns / 1ps
package pat_pkg;

  // Table geometry; SLOTS must stay a power of two (slot = low bits of seq)
  localparam int SLOTS        = 64;
  localparam int HISTORY_BITS = 32;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int HIST_W       = (HISTORY_BITS > 1) ? $clog2(HISTORY_BITS) : 1;
  localparam int LIVE_W       = $clog2(SLOTS + 1);
  localparam int STEP_TOTAL   = 1 + HISTORY_BITS + SLOTS;
  localparam int STEP_W       = $clog2(STEP_TOTAL + 1);

  // Operation codes
  localparam logic [1:0] OP_SEND   = 2'd0;
  localparam logic [1:0] OP_ACK    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_STORED    = 3'd0;
  localparam logic [2:0] KIND_REJECTED  = 3'd1;
  localparam logic [2:0] KIND_DELIVERED = 3'd2;
  localparam logic [2:0] KIND_LOST      = 3'd3;
  localparam logic [2:0] KIND_NONE      = 3'd4;
  localparam logic [2:0] KIND_CLEARED   = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] seq;
    logic [15:0] frames;
    logic [31:0] payload_bits;
    logic [31:0] history;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [15:0]       entry_seq;
    logic [15:0]       entry_frames;
    logic [31:0]       entry_bits;
    logic [LIVE_W-1:0] live_count;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] frames;
    logic [31:0] bits;
  } slot_entry_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    slot_entry_t       wdata;
  } ram_req_t;

endpackage

/* hdl/pat_if.sv */
// Valid/ready channel interfaces for the input and result words.
`timescale 1ns / 1ps
interface pat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] seq;
  logic [15:0] frames;
  logic [31:0] payload_bits;
  logic [31:0] history;
  modport source(output valid, op, seq, frames, payload_bits, history, input ready);
  modport sink(input valid, op, seq, frames, payload_bits, history, output ready);
endinterface

interface pat_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] entry_seq;
  logic [15:0] entry_frames;
  logic [31:0] entry_bits;
  logic [6:0]  live_count;
  logic        last;
  modport source(output valid, kind, entry_seq, entry_frames, entry_bits, live_count, last,
                 input ready);
  modport sink(input valid, kind, entry_seq, entry_frames, entry_bits, live_count, last,
               output ready);
endinterface

/* hdl/pat_slot_ram.sv */
// Slot table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module pat_slot_ram import pat_pkg::*; (
  input  logic        clk,
  input  ram_req_t    req,
  output slot_entry_t rdata
);

  slot_entry_t mem [SLOTS];
  slot_entry_t rdata_r;

  // Write on request, registered read with data in the next cycle; hold data when idle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/pat_ctrl.sv */
// Sequencer: walks acked and scanned slots, live bits, result buffering.
`timescale 1ns / 1ps
module pat_ctrl import pat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  output ram_req_t    ram_req,
  input  slot_entry_t ram_rdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;
  typedef enum logic [1:0] {SK_SEND, SK_DEL, SK_SCAN} step_kind_t;

  state_t            state_r;
  in_word_t          item_r;
  logic [SLOTS-1:0]  live_r, live_nxt;
  logic [LIVE_W-1:0] count_r, count_nxt;
  logic [15:0]       highest_r;
  logic              any_r;
  logic [STEP_W-1:0] step_r, step_end_r;
  logic              s1_v_r;
  step_kind_t        s1_kind_r;
  logic [15:0]       s1_tgt_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              pend_v_r;
  out_word_t         pend_r;
  logic              out_v_r;
  out_word_t         out_r;

  logic              can_out, can_push, adv, iss_ok, s2_go, s2_push, out_load;
  step_kind_t        g_kind;
  logic [15:0]       g_tgt;
  logic [SLOT_W-1:0] g_slot;
  logic              g_v;
  logic [HIST_W-1:0] hidx;
  logic [15:0]       d_scan, d_ack;
  logic              s1_live;
  out_word_t         res;

  assign can_out  = !out_v_r || out_ready;
  assign can_push = !pend_v_r || can_out;
  assign adv      = !s1_v_r || can_push;
  assign iss_ok   = (state_r == ST_RUN) && adv && (step_r != step_end_r);
  assign s2_go    = s1_v_r && can_push;
  assign in_ready = (state_r == ST_IDLE);
  assign hidx     = HIST_W'(step_r - STEP_W'(1));
  assign d_ack    = in_word.seq - highest_r;
  assign out_load = ((state_r == ST_RUN) && s2_push && pend_v_r) ||
                    ((state_r == ST_FIN) && can_out);

  // Pick the slot for the current step
  always_comb begin
    g_kind = SK_SCAN;
    g_tgt  = '0;
    g_slot = '0;
    g_v    = 1'b0;
    if (item_r.op == OP_SEND) begin
      g_kind = SK_SEND;
      g_tgt  = item_r.seq;
      g_slot = item_r.seq[SLOT_W-1:0];
      g_v    = 1'b1;
    end else if (step_r <= STEP_W'(HISTORY_BITS)) begin
      g_kind = SK_DEL;
      g_tgt  = item_r.seq - 16'(step_r);
      g_slot = g_tgt[SLOT_W-1:0];
      g_v    = ((step_r == '0) || item_r.history[hidx]) && live_r[g_slot];
    end else begin
      g_kind = SK_SCAN;
      g_slot = SLOT_W'(step_r - STEP_W'(HISTORY_BITS + 1));
      g_v    = live_r[g_slot];
    end
  end

  // Compare the read entry and decide the result
  assign s1_live = live_r[s1_slot_r];
  assign d_scan  = highest_r - ram_rdata.seq;

  always_comb begin
    live_nxt      = live_r;
    count_nxt     = count_r;
    s2_push       = 1'b0;
    res           = '0;
    ram_req.re    = iss_ok && g_v;
    ram_req.raddr = g_slot;
    ram_req.we    = 1'b0;
    ram_req.waddr = s1_slot_r;
    ram_req.wdata = '{seq: item_r.seq, frames: item_r.frames, bits: item_r.payload_bits};
    if (s2_go) begin
      case (s1_kind_r)
        SK_SEND: begin
          s2_push = 1'b1;
          if (s1_live && (ram_rdata.seq != s1_tgt_r)) begin
            res = '{KIND_REJECTED, item_r.seq, 16'd0, 32'd0, count_r, 1'b0};
          end else begin
            ram_req.we          = 1'b1;
            live_nxt[s1_slot_r] = 1'b1;
            if (!s1_live) begin
              count_nxt = count_r + LIVE_W'(1);
            end
            res = '{KIND_STORED, item_r.seq, item_r.frames, item_r.payload_bits,
                    count_nxt, 1'b0};
          end
        end
        SK_DEL: begin
          if (s1_live && (ram_rdata.seq == s1_tgt_r)) begin
            s2_push             = 1'b1;
            live_nxt[s1_slot_r] = 1'b0;
            count_nxt           = count_r - LIVE_W'(1);
            res = '{KIND_DELIVERED, ram_rdata.seq, ram_rdata.frames, ram_rdata.bits,
                    count_nxt, 1'b0};
          end
        end
        SK_SCAN: begin
          if (s1_live && !d_scan[15] && (d_scan > 16'(HISTORY_BITS))) begin
            s2_push             = 1'b1;
            live_nxt[s1_slot_r] = 1'b0;
            count_nxt           = count_r - LIVE_W'(1);
            res = '{KIND_LOST, ram_rdata.seq, ram_rdata.frames, ram_rdata.bits,
                    count_nxt, 1'b0};
          end
        end
        default: ;
      endcase
    end
    if ((state_r == ST_IDLE) && in_valid && (in_word.op == OP_CLEAR)) begin
      live_nxt  = '0;
      count_nxt = '0;
    end
  end

  // Hold state, advance the walk, buffer one word to flag the final one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      live_r    <= '0;
      count_r   <= '0;
      highest_r <= '0;
      any_r     <= 1'b0;
      step_r    <= '0;
      step_end_r <= '0;
      s1_v_r    <= 1'b0;
      pend_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      live_r  <= live_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r <= in_word;
            step_r <= '0;
            case (in_word.op)
              OP_SEND: begin
                step_end_r <= STEP_W'(1);
                state_r    <= ST_RUN;
              end
              OP_ACK: begin
                step_end_r <= STEP_W'(STEP_TOTAL);
                if (!any_r || ((d_ack != 16'd0) && !d_ack[15])) begin
                  highest_r <= in_word.seq;
                  any_r     <= 1'b1;
                end
                state_r <= ST_RUN;
              end
              OP_CLEAR: begin
                highest_r <= '0;
                any_r     <= 1'b0;
                pend_v_r  <= 1'b1;
                pend_r    <= '{KIND_CLEARED, in_word.seq, 16'd0, 32'd0, LIVE_W'(0), 1'b0};
                state_r   <= ST_FIN;
              end
              default: ;
            endcase
          end
        end
        ST_RUN: begin
          if (adv) begin
            s1_v_r    <= iss_ok && g_v;
            s1_kind_r <= g_kind;
            s1_tgt_r  <= g_tgt;
            s1_slot_r <= g_slot;
          end
          if (iss_ok) begin
            step_r <= step_r + STEP_W'(1);
          end
          if (s2_push) begin
            if (pend_v_r) begin
              out_r <= pend_r;
            end
            pend_r   <= res;
            pend_v_r <= 1'b1;
          end
          if ((step_r == step_end_r) && !s1_v_r) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (can_out) begin
            if (pend_v_r) begin
              out_r <= '{pend_r.kind, pend_r.entry_seq, pend_r.entry_frames,
                         pend_r.entry_bits, pend_r.live_count, 1'b1};
            end else begin
              out_r <= '{KIND_NONE, item_r.seq, 16'd0, 32'd0, count_r, 1'b1};
            end
            pend_v_r <= 1'b0;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

endmodule

/* hdl/packet_ack_tracker.sv */
// An ack walks 1 + HISTORY_BITS acked slots and then all SLOTS slots, one per
// cycle through the slot memory read port unless the result side stalls.
// Throughput: one word at a time; the next is accepted once the last result is queued.
// Reset clears live bits, live count and highest acked; the slot memory is not
// cleared, since an entry is used only while its live bit is set.
`timescale 1ns / 1ps
module packet_ack_tracker import pat_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  pat_in_if.sink   in_ch,
  pat_out_if.source out_ch
);

  in_word_t    in_word;
  out_word_t   out_word;
  ram_req_t    ram_req;
  slot_entry_t ram_rdata;

  // Pack and unpack the channel words
  assign in_word = '{op: in_ch.op, seq: in_ch.seq, frames: in_ch.frames,
                     payload_bits: in_ch.payload_bits, history: in_ch.history};
  assign out_ch.kind         = out_word.kind;
  assign out_ch.entry_seq    = out_word.entry_seq;
  assign out_ch.entry_frames = out_word.entry_frames;
  assign out_ch.entry_bits   = out_word.entry_bits;
  assign out_ch.live_count   = out_word.live_count;
  assign out_ch.last         = out_word.last;

  pat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_word   (in_word),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  pat_slot_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

/* hdl/pat_checker.sv */
// Port-level checks for the tracker, bound to the top level.
`timescale 1ns / 1ps
module pat_checker import pat_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [15:0] out_entry_seq,
  input logic [6:0]  out_live_count,
  input logic        out_last
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_seq) && $stable(out_kind))
    else $error("result word changed under stall");

  // A word that makes results closes the input side
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_SEND || in_op == OP_ACK || in_op == OP_CLEAR)
    |=> !in_ready)
    else $error("input accepted while busy");

  // Live count stays within the table
  a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_live_count <= 7'(SLOTS))
    else $error("live count out of range");

  // Clear reports an empty table as its only word
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CLEARED |-> out_live_count == '0 && out_last)
    else $error("clear word malformed");

  // Send results are single words
  a_send_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_STORED || out_kind == KIND_REJECTED) |-> out_last)
    else $error("send result not final");

endmodule

bind packet_ack_tracker pat_checker u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_op          (in_ch.op),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_entry_seq  (out_ch.entry_seq),
  .out_live_count (out_ch.live_count),
  .out_last       (out_ch.last)
);

/* verif/pat_ack_checker.sv */
// Checker for the packet acknowledgement tracker: predicts and compares result words.
`timescale 1ns / 1ps
module pat_ack_checker import pat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pat_in_if.sink      in_mon,
  pat_out_if.sink     out_mon,
  output int          fail_count,
  output int          pending
);

  // Prediction state
  logic [15:0] tab_seq [SLOTS];
  logic [15:0] tab_frames [SLOTS];
  logic [31:0] tab_bits [SLOTS];
  logic        tab_live [SLOTS];
  logic [15:0] top_acked;
  logic        seen_ack;
  int          live_cnt;
  out_word_t   due_q[$];

  assign pending = due_q.size();

  function automatic void push_word(logic [2:0] k, logic [15:0] s, logic [15:0] f,
                                    logic [31:0] b);
    out_word_t w;
    w.kind = k;
    w.entry_seq = s;
    w.entry_frames = f;
    w.entry_bits = b;
    w.live_count = live_cnt[LIVE_W-1:0];
    w.last = 1'b0;
    due_q.insert(due_q.size(), w);
  endfunction

  function automatic bit free_seq(logic [15:0] s);
    int i;
    i = s % SLOTS;
    if (!tab_live[i] || tab_seq[i] != s) return 1'b0;
    tab_live[i] = 1'b0;
    if (live_cnt > 0) live_cnt--;
    push_word(KIND_DELIVERED, tab_seq[i], tab_frames[i], tab_bits[i]);
    return 1'b1;
  endfunction

  // Work out the result words of one accepted input word
  function automatic void predict_word(in_word_t w);
    int i;
    int n;
    logic [15:0] d;
    n = 0;
    case (w.op)
      OP_SEND: begin
        i = w.seq % SLOTS;
        if (tab_live[i] && tab_seq[i] != w.seq) begin
          push_word(KIND_REJECTED, w.seq, 16'd0, 32'd0);
        end else begin
          if (!tab_live[i]) live_cnt++;
          tab_seq[i] = w.seq;
          tab_frames[i] = w.frames;
          tab_bits[i] = w.payload_bits;
          tab_live[i] = 1'b1;
          push_word(KIND_STORED, w.seq, w.frames, w.payload_bits);
        end
        n = 1;
      end
      OP_CLEAR: begin
        for (i = 0; i < SLOTS; i++) tab_live[i] = 1'b0;
        top_acked = '0;
        seen_ack = 1'b0;
        live_cnt = 0;
        push_word(KIND_CLEARED, w.seq, 16'd0, 32'd0);
        n = 1;
      end
      OP_ACK: begin
        n += free_seq(w.seq);
        for (i = 0; i < HISTORY_BITS; i++)
          if (w.history[i]) n += free_seq(w.seq - 16'd1 - 16'(i));
        d = w.seq - top_acked;
        if (!seen_ack || (d != 0 && !d[15])) begin
          top_acked = w.seq;
          seen_ack = 1'b1;
        end
        // Sweep out entries that trail the newest ack too far
        for (i = 0; i < SLOTS; i++) begin
          if (tab_live[i]) begin
            d = top_acked - tab_seq[i];
            if (!d[15] && d > HISTORY_BITS) begin
              tab_live[i] = 1'b0;
              if (live_cnt > 0) live_cnt--;
              push_word(KIND_LOST, tab_seq[i], tab_frames[i], tab_bits[i]);
              n++;
            end
          end
        end
        if (n == 0) begin
          push_word(KIND_NONE, w.seq, 16'd0, 32'd0);
          n = 1;
        end
      end
      default: ;
    endcase
    if (n > 0) due_q[due_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    in_word_t  iw;
    out_word_t got;
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) tab_live[i] = 1'b0;
      top_acked = '0;
      seen_ack = 1'b0;
      live_cnt = 0;
      due_q.delete();
      fail_count = 0;
    end else begin
      // Check the result word first, then predict the accepted input word
      if (out_mon.valid && out_mon.ready) begin
        got.kind = out_mon.kind;
        got.entry_seq = out_mon.entry_seq;
        got.entry_frames = out_mon.entry_frames;
        got.entry_bits = out_mon.entry_bits;
        got.live_count = out_mon.live_count;
        got.last = out_mon.last;
        if (due_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %p", got);
        end else begin
          want = due_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        iw.op = in_mon.op;
        iw.seq = in_mon.seq;
        iw.frames = in_mon.frames;
        iw.payload_bits = in_mon.payload_bits;
        iw.history = in_mon.history;
        predict_word(iw);
      end
    end
  end

endmodule

/* verif/packet_ack_tracker_test.sv */
// Testbench top for the packet acknowledgement tracker: stimulus and verdict.
`timescale 1ns / 1ps
module packet_ack_tracker_test import pat_pkg::*; ();

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   base;
  bit   stall_on;

  pat_in_if  in_ch ();
  pat_out_if out_ch ();

  packet_ack_tracker u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  pat_ack_checker u_chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                         .fail_count(fail_count), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random while stall_on is set; other stretches never stall
  initial begin
    int run;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      run = $urandom_range(1, 12);
      repeat (run) begin
        out_ch.ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
        @(negedge clk);
      end
    end
  end

  // Present one word and hold it until accepted
  task automatic put_word(logic [1:0] op, logic [15:0] s, logic [15:0] f,
                          logic [31:0] b, logic [31:0] h);
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.seq <= s;
    in_ch.frames <= f;
    in_ch.payload_bits <= b;
    in_ch.history <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic rand_send(logic [15:0] s);
    put_word(OP_SEND, s, 16'($urandom), $urandom, $urandom);
  endtask

  initial begin
    int burst;
    int pick;
    logic [15:0] s;
    rst_n = 1'b0;
    stall_on = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_SEND;
    in_ch.seq = '0;
    in_ch.frames = '0;
    in_ch.payload_bits = '0;
    in_ch.history = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, resend, rejection, empty ack, first ack, wrap, clear
    put_word(OP_ACK, 16'd5, '0, '0, '0);
    put_word(OP_CLEAR, 16'hffff, '0, '0, '0);
    put_word(OP_SEND, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff);
    put_word(OP_SEND, 16'h0000, 16'h0000, 32'h0, 32'h0);
    put_word(OP_SEND, 16'h0000, 16'h1234, 32'h89abcdef, 32'h0);
    put_word(OP_SEND, 16'h0040, 16'h1, 32'h1, 32'h0);
    put_word(OP_SEND, 16'h0001, 16'h5555, 32'haaaaaaaa, 32'h0);
    put_word(OP_SEND, 16'h0002, 16'haaaa, 32'h55555555, 32'h0);
    put_word(OP_UNUSED, 16'h0002, 16'h1, 32'h1, 32'h1);
    put_word(OP_ACK, 16'h0001, '0, '0, 32'h00000003);
    put_word(OP_ACK, 16'h0001, '0, '0, 32'h00000001);
    put_word(OP_SEND, 16'h0003, 16'h7, 32'h7, 32'h0);
    put_word(OP_ACK, 16'h0060, '0, '0, 32'hffffffff);
    put_word(OP_SEND, 16'h7fff, 16'h1, 32'h2, 32'h0);
    put_word(OP_ACK, 16'hffe0, '0, '0, 32'h80000000);
    put_word(OP_CLEAR, 16'h0, '0, '0, '0);
    drain();

    // Random: a sliding window of sends and acks with noise
    stall_on = 1'b1;
    base = $urandom;
    for (int item = 0; item < 170; ) begin
      burst = $urandom_range(1, 10);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          s = 16'(base);
          base = base + $urandom_range(0, 2);
          rand_send(s);
        end else if (pick < 85) begin
          s = 16'(base - $urandom_range(0, 6));
          put_word(OP_ACK, s, 16'($urandom), $urandom, $urandom);
        end else if (pick < 90) begin
          put_word(OP_ACK, 16'(base + $urandom_range(40, 200)), '0, '0, $urandom);
        end else if (pick < 94) begin
          rand_send(16'(base - $urandom_range(60, 70)));
        end else if (pick < 97) begin
          put_word(OP_SEND, 16'($urandom), 16'($urandom), $urandom, $urandom);
        end else begin
          put_word(OP_CLEAR, 16'($urandom), 16'($urandom), $urandom, $urandom);
        end
        item++;
      end
      if (item > 80 && item < 90) begin
        stall_on = 1'b0;
        drain();
        stall_on = 1'b1;
      end else begin
        gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
      end
    end
    drain();
    repeat (200) @(negedge clk);

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* packet_ack_tracker.f */
hdl/pat_pkg.sv
hdl/pat_if.sv
hdl/pat_slot_ram.sv
hdl/pat_ctrl.sv
hdl/packet_ack_tracker.sv
hdl/pat_checker.sv
verif/pat_ack_checker.sv
verif/packet_ack_tracker_test.sv
